### hw/rtl/psa_pkg.sv
package psa_pkg;

    localparam int NUM_PIXELS_DEF  = 65536;
    localparam int NUM_CLASSES_DEF = 4;

    localparam int SUM_W   = 37;
    localparam int SQ_W    = 51;
    localparam int COUNT_W = 20;
    localparam int STAT_W  = 20;

    // opcodes
    localparam logic [1:0] OP_ACCUM = 2'd0;
    localparam logic [1:0] OP_EOF   = 2'd1;
    localparam logic [1:0] OP_READ  = 2'd2;

    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

    typedef struct packed {
        logic [1:0]         opcode;
        logic [1:0]         class_index;
        logic [15:0]        pixel_index;
        logic signed [15:0] pixel_value;
    } t_in_item;

    typedef struct packed {
        logic signed [STAT_W-1:0] mean_q4;
        logic [STAT_W-1:0]        sigma_q4;
        logic [COUNT_W-1:0]       frame_count;
        logic                     no_frames;
        logic                     saturated;
    } t_out_item;

    typedef struct packed {
        logic signed [15:0] pixel_threshold;
    } t_cfg_item;

    typedef struct packed {
        logic signed [SUM_W-1:0] sum;
        logic [SQ_W-1:0]         sumsq;
        logic                    mark;
    } t_entry;

    typedef struct packed {
        logic signed [SUM_W-1:0] sum;
        logic [SQ_W-1:0]         sumsq;
        logic [COUNT_W-1:0]      n;
    } t_math_req;

    typedef struct packed {
        logic                     done;
        logic signed [STAT_W-1:0] mean_q4;
        logic [STAT_W-1:0]        sigma_q4;
    } t_math_rsp;

endpackage

### hw/rtl/psa_chan_if.sv
interface psa_chan_if #(parameter type T = logic);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

### hw/rtl/psa_store.sv
module psa_store #(
    parameter int DEPTH = 4,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_rd_en,
    input  logic [AW-1:0]    i_rd_addr,
    output psa_pkg::t_entry  o_rd_data,
    input  logic             i_wr_en,
    input  logic [AW-1:0]    i_wr_addr,
    input  psa_pkg::t_entry  i_wr_data,
    output logic             o_busy
);
    import psa_pkg::*;

    t_entry        mem [DEPTH];
    t_entry        r_rd_data;
    logic          r_clearing;
    logic [AW-1:0] r_clr_addr;

    // clearing pass after reset, one entry a cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clearing <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clearing) begin
            if (r_clr_addr == AW'(DEPTH - 1)) begin
                r_clearing <= 1'b0;
            end
            r_clr_addr <= r_clr_addr + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_clearing) begin
            mem[r_clr_addr] <= '0;
        end else if (i_wr_en) begin
            mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;
    assign o_busy    = r_clearing;
endmodule

### hw/rtl/psa_math.sv
module psa_math (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  psa_pkg::t_math_req  i_req,
    output psa_pkg::t_math_rsp  o_rsp
);
    import psa_pkg::*;

    localparam int AW_ALU = 75;

    typedef enum logic [2:0] {
        M_IDLE, M_MDIV, M_MULA, M_MULB, M_CHECK, M_SQRT, M_SDIV
    } t_mstate;

    t_mstate             r_state;
    logic [AW_ALU-1:0]   r_acc;
    logic [AW_ALU-1:0]   r_mc;
    logic [SUM_W-1:0]    r_mp;
    logic [SUM_W-1:0]    r_mag;
    logic [SQ_W-1:0]     r_q;
    logic [COUNT_W-1:0]  r_n;
    logic                r_neg;
    logic [40:0]         r_quo;
    logic [79:0]         r_x;
    logic [39:0]         r_root;
    logic [5:0]          r_cnt;
    logic                r_done;
    logic [STAT_W-1:0]   r_mean;
    logic [STAT_W-1:0]   r_sigma;

    logic [AW_ALU-1:0]   alu_a;
    logic [AW_ALU-1:0]   alu_b;
    logic                alu_sub;
    logic [AW_ALU-1:0]   alu_r;
    logic                alu_borrow;
    logic [40:0]         quo_next;
    logic [39:0]         root_next;
    logic [SUM_W-1:0]    req_mag;

    // shared add/subtract unit
    always_comb begin
        alu_a   = r_acc;
        alu_b   = '0;
        alu_sub = 1'b0;
        case (r_state)
            M_MDIV, M_SDIV: begin
                alu_a   = AW_ALU'({r_acc[20:0], r_quo[40]});
                alu_b   = AW_ALU'(r_n);
                alu_sub = 1'b1;
            end
            M_MULA: begin
                alu_b = r_mc;
            end
            M_MULB: begin
                alu_b   = r_mc;
                alu_sub = 1'b1;
            end
            M_SQRT: begin
                alu_a   = AW_ALU'({r_acc[41:0], r_x[79:78]});
                alu_b   = AW_ALU'({r_root, 2'b01});
                alu_sub = 1'b1;
            end
            default: begin
                alu_b = '0;
            end
        endcase
        alu_r      = alu_a + (alu_sub ? ~alu_b : alu_b) + AW_ALU'(alu_sub);
        alu_borrow = alu_r[AW_ALU-1];
        quo_next   = {r_quo[39:0], ~alu_borrow};
        root_next  = {r_root[38:0], ~alu_borrow};
        req_mag    = i_req.sum[SUM_W-1] ? (~i_req.sum + 1'b1) : i_req.sum;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= M_IDLE;
            r_done  <= 1'b0;
        end else begin
            // done on the last sigma division step or on a non-positive variance
            r_done <= ((r_state == M_SDIV) && (r_cnt == 6'd1)) ||
                      ((r_state == M_CHECK) && (r_acc[AW_ALU-1] || (r_acc == '0)));
            case (r_state)
                M_IDLE: begin
                    if (i_start) begin
                        r_n     <= i_req.n;
                        r_q     <= i_req.sumsq;
                        r_mag   <= req_mag;
                        r_neg   <= i_req.sum[SUM_W-1];
                        r_quo   <= {req_mag, 4'b0};
                        r_acc   <= '0;
                        r_cnt   <= 6'd41;
                        r_state <= M_MDIV;
                    end
                end
                M_MDIV, M_SDIV: begin
                    r_quo <= quo_next;
                    if (r_cnt == 6'd1) begin
                        if (r_state == M_MDIV) begin
                            // mean clamp, sign restored
                            if (r_neg) begin
                                r_mean <= (quo_next > 41'd524288) ? 20'h80000
                                                                  : 20'(~quo_next + 1'b1);
                            end else begin
                                r_mean <= (quo_next > 41'd524272) ? 20'd524272
                                                                  : quo_next[19:0];
                            end
                            r_acc   <= '0;
                            r_mc    <= AW_ALU'(r_q);
                            r_mp    <= SUM_W'(r_n);
                            r_cnt   <= 6'd20;
                            r_state <= M_MULA;
                        end else begin
                            r_sigma <= (quo_next > 41'd1048575) ? '1 : quo_next[19:0];
                            r_state <= M_IDLE;
                        end
                    end else begin
                        r_acc <= alu_borrow ? alu_a : alu_r;
                        r_cnt <= r_cnt - 1'b1;
                    end
                end
                M_MULA, M_MULB: begin
                    if (r_mp[0]) begin
                        r_acc <= alu_r;
                    end
                    if (r_cnt == 6'd1) begin
                        if (r_state == M_MULA) begin
                            r_mc    <= AW_ALU'(r_mag);
                            r_mp    <= r_mag;
                            r_cnt   <= 6'd37;
                            r_state <= M_MULB;
                        end else begin
                            r_state <= M_CHECK;
                        end
                    end else begin
                        r_mc  <= {r_mc[AW_ALU-2:0], 1'b0};
                        r_mp  <= {1'b0, r_mp[SUM_W-1:1]};
                        r_cnt <= r_cnt - 1'b1;
                    end
                end
                M_CHECK: begin
                    // n*sumsq - sum^2 not positive gives zero sigma
                    if (r_acc[AW_ALU-1] || (r_acc == '0)) begin
                        r_sigma <= '0;
                        r_state <= M_IDLE;
                    end else begin
                        r_x     <= {r_acc[71:0], 8'b0};
                        r_acc   <= '0;
                        r_root  <= '0;
                        r_cnt   <= 6'd40;
                        r_state <= M_SQRT;
                    end
                end
                M_SQRT: begin
                    r_root <= root_next;
                    if (r_cnt == 6'd1) begin
                        r_quo   <= {1'b0, root_next};
                        r_acc   <= '0;
                        r_cnt   <= 6'd41;
                        r_state <= M_SDIV;
                    end else begin
                        r_acc <= alu_borrow ? alu_a : alu_r;
                        r_x   <= {r_x[77:0], 2'b00};
                        r_cnt <= r_cnt - 1'b1;
                    end
                end
                default: begin
                    r_state <= M_IDLE;
                end
            endcase
        end
    end

    assign o_rsp = '{done: r_done, mean_q4: r_mean, sigma_q4: r_sigma};
endmodule

### hw/rtl/pixel_stats_accumulator.sv
// Per-class, per-pixel sum and sum of squares of the pixel values above the
// threshold, with a frame count per class. After reset the block runs a
// clearing pass over all NUM_PIXELS * NUM_CLASSES entries of the pixel store
// (262144 at the defaults) and takes no item meanwhile; threshold writes are
// taken at any time. An accumulate item is a store read and then a
// read-modify-write; the block takes no new item until the last is through.
// A read item of a class with frames steps one shared 75-bit adder through a
// 41-step mean division, a 57-step shift-add n*sumsq - sum^2, a 40-step square
// root and a 41-step sigma division, plus a compare step and the store read,
// start, finish and output load. A read of a class without frames skips the
// math and an out-of-range read also skips the store read; each may wait for
// a free output register. A finished result waits in an output register, so
// accumulation goes on while it is not yet taken.
module pixel_stats_accumulator #(
    parameter int NUM_PIXELS  = psa_pkg::NUM_PIXELS_DEF,
    parameter int NUM_CLASSES = psa_pkg::NUM_CLASSES_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    psa_chan_if.sink   i_in,
    psa_chan_if.source o_out,
    psa_chan_if.sink   i_cfg
);
    import psa_pkg::*;

    localparam int DEPTH = NUM_PIXELS * NUM_CLASSES;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW    = (NUM_CLASSES > 1) ? $clog2(NUM_CLASSES) : 1;

    typedef enum logic [2:0] {
        S_IDLE, S_ACC_WR, S_RD_START, S_RD_MATH, S_RD_OUT
    } t_state;

    t_state                r_state;
    logic signed [15:0]    r_thr;
    logic [COUNT_W-1:0]    r_count [NUM_CLASSES];
    logic [AW-1:0]         r_addr;
    logic signed [15:0]    r_val;
    logic [31:0]           r_sq;
    logic [COUNT_W-1:0]    r_n;
    t_out_item             r_res;
    t_out_item             r_out;
    logic                  r_out_valid;

    t_in_item              in_item;
    logic                  accept;
    logic                  busy;
    logic                  cls_ok;
    logic                  pix_ok;
    logic [CW-1:0]         cls_idx;
    logic [31:0]           addr_full;
    logic [AW-1:0]         addr;
    t_entry                rd_data;
    t_entry                wr_data;
    logic                  rd_en;
    logic                  wr_en;
    logic signed [SUM_W:0] sum_ext;
    logic [SQ_W:0]         sq_ext;
    t_math_req             math_req;
    t_math_rsp             math_rsp;
    logic                  math_start;

    assign in_item   = i_in.data;
    assign i_in.ready = (r_state == S_IDLE) && !busy;
    assign accept    = i_in.valid && i_in.ready;
    assign i_cfg.ready = 1'b1;

    // range checks and flat store address
    assign cls_ok    = 32'(in_item.class_index) < 32'(NUM_CLASSES);
    assign pix_ok    = 32'(in_item.pixel_index) < 32'(NUM_PIXELS);
    assign cls_idx   = CW'(32'(in_item.class_index));
    assign addr_full = 32'(in_item.class_index) * 32'(NUM_PIXELS)
                     + 32'(in_item.pixel_index);
    assign addr      = AW'(addr_full);

    // store read on accept of an accumulate that passes or of a read
    assign rd_en = accept && cls_ok && pix_ok &&
                   (((in_item.opcode == OP_ACCUM) && (in_item.pixel_value > r_thr)) ||
                    (in_item.opcode == OP_READ));

    // saturating update of the read entry
    always_comb begin
        sum_ext = (SUM_W + 1)'(rd_data.sum) + (SUM_W + 1)'(r_val);
        sq_ext  = (SQ_W + 1)'(rd_data.sumsq) + (SQ_W + 1)'(r_sq);
        wr_data = rd_data;
        if (sum_ext[SUM_W] != sum_ext[SUM_W-1]) begin
            wr_data.sum  = sum_ext[SUM_W] ? {1'b1, {(SUM_W - 1){1'b0}}}
                                          : {1'b0, {(SUM_W - 1){1'b1}}};
            wr_data.mark = 1'b1;
        end else begin
            wr_data.sum = sum_ext[SUM_W-1:0];
        end
        if (sq_ext[SQ_W]) begin
            wr_data.sumsq = '1;
            wr_data.mark  = 1'b1;
        end else begin
            wr_data.sumsq = sq_ext[SQ_W-1:0];
        end
    end
    assign wr_en = (r_state == S_ACC_WR);

    psa_store #(.DEPTH(DEPTH)) u_store (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (rd_en),
        .i_rd_addr (addr),
        .o_rd_data (rd_data),
        .i_wr_en   (wr_en),
        .i_wr_addr (r_addr),
        .i_wr_data (wr_data),
        .o_busy    (busy)
    );

    assign math_req   = '{sum: rd_data.sum, sumsq: rd_data.sumsq, n: r_n};
    assign math_start = (r_state == S_RD_START) && (r_n != '0);

    psa_math u_math (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (math_start),
        .i_req   (math_req),
        .o_rsp   (math_rsp)
    );

    // threshold register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr <= '0;
        end else if (i_cfg.valid && i_cfg.ready) begin
            r_thr <= i_cfg.data.pixel_threshold;
        end
    end

    // sequencer, frame counts and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            for (int i = 0; i < NUM_CLASSES; i++) begin
                r_count[i] <= '0;
            end
        end else begin
            // the output load below takes over while a result is pending
            if (o_out.ready && (r_state != S_RD_OUT)) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_addr <= addr;
                        r_val  <= in_item.pixel_value;
                        r_sq   <= 32'(in_item.pixel_value * in_item.pixel_value);
                        case (in_item.opcode)
                            OP_ACCUM: begin
                                if (rd_en) begin
                                    r_state <= S_ACC_WR;
                                end
                            end
                            OP_EOF: begin
                                if (cls_ok && (r_count[cls_idx] != COUNT_MAX)) begin
                                    r_count[cls_idx] <= r_count[cls_idx] + 1'b1;
                                end
                            end
                            OP_READ: begin
                                if (cls_ok && pix_ok) begin
                                    r_n     <= r_count[cls_idx];
                                    r_state <= S_RD_START;
                                end else begin
                                    // out-of-range read: zeros with no_frames
                                    r_res   <= '{mean_q4: '0, sigma_q4: '0,
                                                 frame_count: '0, no_frames: 1'b1,
                                                 saturated: 1'b0};
                                    r_state <= S_RD_OUT;
                                end
                            end
                            default: begin
                                r_state <= S_IDLE;
                            end
                        endcase
                    end
                end
                S_ACC_WR: begin
                    r_state <= S_IDLE;
                end
                S_RD_START: begin
                    r_res.frame_count <= r_n;
                    r_res.saturated   <= rd_data.mark;
                    r_res.no_frames   <= (r_n == '0);
                    r_res.mean_q4     <= '0;
                    r_res.sigma_q4    <= '0;
                    r_state           <= (r_n == '0) ? S_RD_OUT : S_RD_MATH;
                end
                S_RD_MATH: begin
                    if (math_rsp.done) begin
                        r_res.mean_q4  <= math_rsp.mean_q4;
                        r_res.sigma_q4 <= math_rsp.sigma_q4;
                        r_state        <= S_RD_OUT;
                    end
                end
                S_RD_OUT: begin
                    // wait until the output register is free
                    if (!r_out_valid || o_out.ready) begin
                        r_out       <= r_res;
                        r_out_valid <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_out.valid = r_out_valid;
    assign o_out.data  = r_out;
endmodule

### verif/pixel_stats_accumulator_test.sv
`timescale 1ns / 1ps

// per-pixel statistics: running copy of the sum, sum of squares and frame counts
class pixel_stats_scoreboard;
    localparam longint SUM_HI   = 64'sd68719476735;
    localparam longint SUM_LO   = -64'sd68719476736;
    localparam logic [63:0] SQ_HI = 64'd2251799813685247;
    localparam int MEAN_HI = 524272;
    localparam int MEAN_LO = -524288;
    localparam int SIGMA_HI = 1048575;

    longint      sum_store[int];
    logic [63:0] sq_store[int];
    bit          sat_store[int];
    int          frames[4];
    int          threshold;
    psa_pkg::t_out_item stats_due[$];
    int mismatches;
    int reads_seen;

    function new();
        threshold = 0;
        mismatches = 0;
        reads_seen = 0;
        foreach (frames[i]) frames[i] = 0;
    endfunction

    function void set_threshold(logic signed [15:0] thr);
        threshold = int'(thr);
    endfunction

    function int pending();
        return stats_due.size();
    endfunction

    function psa_pkg::t_out_item pixel_stats(int addr, int n);
        psa_pkg::t_out_item r;
        longint s;
        longint unsigned mag, q;
        longint mean;
        logic [127:0] a, b, d, cand;
        logic [63:0] root, sigma;
        s = sum_store.exists(addr) ? sum_store[addr] : 0;
        mag = (s < 0) ? -s : s;
        mean = 0;
        sigma = 0;
        if (n != 0) begin
            q = (mag * 16) / n;
            mean = (s < 0) ? -longint'(q) : longint'(q);
            if (mean > MEAN_HI) mean = MEAN_HI;
            if (mean < MEAN_LO) mean = MEAN_LO;
            a = 128'(sq_store.exists(addr) ? sq_store[addr] : 64'd0) * 128'(n);
            b = 128'(mag) * 128'(mag);
            if (a > b) begin
                d = (a - b) << 8;
                root = 0;
                for (int bt = 39; bt >= 0; bt--) begin
                    cand = 128'(root | (64'd1 << bt));
                    if (cand * cand <= d) root = cand[63:0];
                end
                sigma = root / n;
                if (sigma > SIGMA_HI) sigma = SIGMA_HI;
            end
        end
        r.mean_q4     = mean[19:0];
        r.sigma_q4    = sigma[19:0];
        r.frame_count = n[19:0];
        r.no_frames   = (n == 0);
        r.saturated   = sat_store.exists(addr) ? sat_store[addr] : 1'b0;
        return r;
    endfunction

    // update the pixel store for one accepted item, queue a result for reads
    function void note_input(psa_pkg::t_in_item it);
        int cls, pix, addr, val;
        longint s;
        logic [63:0] sq, qv;
        psa_pkg::t_out_item r;
        cls = int'(it.class_index);
        pix = int'(it.pixel_index);
        val = int'(it.pixel_value);
        addr = cls * 65536 + pix;
        case (it.opcode)
            psa_pkg::OP_ACCUM: begin
                if (val > threshold) begin
                    s  = (sum_store.exists(addr) ? sum_store[addr] : 0) + val;
                    sq = 64'(longint'(val) * longint'(val));
                    qv = sq_store.exists(addr) ? sq_store[addr] : 64'd0;
                    if (!sat_store.exists(addr)) sat_store[addr] = 0;
                    if (s > SUM_HI) begin s = SUM_HI; sat_store[addr] = 1; end
                    if (s < SUM_LO) begin s = SUM_LO; sat_store[addr] = 1; end
                    if (qv > SQ_HI - sq) begin
                        qv = SQ_HI;
                        sat_store[addr] = 1;
                    end else begin
                        qv = qv + sq;
                    end
                    sum_store[addr] = s;
                    sq_store[addr] = qv;
                end
            end
            psa_pkg::OP_EOF: begin
                if (frames[cls] < SIGMA_HI) frames[cls]++;
            end
            psa_pkg::OP_READ: begin
                r = pixel_stats(addr, frames[cls]);
                stats_due.push_back(r);
            end
            default: ;
        endcase
    endfunction

    function void check_result(psa_pkg::t_out_item got);
        psa_pkg::t_out_item exp_r;
        if (stats_due.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected result %p", got);
            return;
        end
        exp_r = stats_due.pop_front();
        reads_seen++;
        if (got.mean_q4 !== exp_r.mean_q4 || got.sigma_q4 !== exp_r.sigma_q4 ||
            got.frame_count !== exp_r.frame_count || got.no_frames !== exp_r.no_frames ||
            got.saturated !== exp_r.saturated) begin
            mismatches++;
            if (mismatches <= 10)
                $display({"stats mismatch: exp mean %0d sigma %0d n %0d nf %0b sat %0b,",
                          " got mean %0d sigma %0d n %0d nf %0b sat %0b"},
                         exp_r.mean_q4, exp_r.sigma_q4, exp_r.frame_count,
                         exp_r.no_frames, exp_r.saturated, got.mean_q4, got.sigma_q4,
                         got.frame_count, got.no_frames, got.saturated);
        end
    endfunction
endclass

module pixel_stats_accumulator_test;
    import psa_pkg::*;

    logic i_clk;
    logic i_rst_n;

    psa_chan_if #(.T(t_in_item))  pix_ch();
    psa_chan_if #(.T(t_out_item)) stat_ch();
    psa_chan_if #(.T(t_cfg_item)) thr_ch();

    pixel_stats_accumulator uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (pix_ch),
        .o_out   (stat_ch),
        .i_cfg   (thr_ch)
    );

    pixel_stats_scoreboard sb;
    int burst_left;
    int sent_items;
    int accum_items;
    int stall_mode;
    int stall_left;
    int hot_pix[8];

    initial i_clk = 0;
    always begin
        #2 i_clk = 1;
        #2 i_clk = 0;
    end

    // hard limit: clearing pass plus a slow run, several times over
    initial begin
        #20ms;
        $display("[FAIL] regression broken");
        $finish;
    end

    // result side: stall mode changes every so often, incl. always-ready stretches
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            stat_ch.ready <= 1'b0;
            stall_mode <= 0;
            stall_left <= 0;
        end else begin
            if (stat_ch.valid && stat_ch.ready && sb != null)
                sb.check_result(stat_ch.data);
            if (stall_left == 0) begin
                stall_mode <= $urandom_range(0, 3);
                stall_left <= $urandom_range(20, 400);
            end else begin
                stall_left <= stall_left - 1;
            end
            case (stall_mode)
                0: stat_ch.ready <= 1'b1;
                1: stat_ch.ready <= ($urandom_range(0, 1) == 0);
                2: stat_ch.ready <= ($urandom_range(0, 7) == 0);
                default: stat_ch.ready <= ($urandom_range(0, 3) != 0);
            endcase
        end
    end

    // send one item, with burst gaps in front of it
    task automatic send_item(t_in_item it);
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            if ($urandom_range(0, 3) != 0) begin
                pix_ch.valid <= 1'b0;
                repeat ($urandom_range(1, 12)) @(posedge i_clk);
            end
        end
        burst_left--;
        pix_ch.valid <= 1'b1;
        pix_ch.data  <= it;
        do @(posedge i_clk); while (!pix_ch.ready);
        sb.note_input(it);
        sent_items++;
        if (it.opcode == OP_ACCUM) accum_items++;
    endtask

    task automatic send_op(logic [1:0] op, int cls, int pix, int val);
        t_in_item it;
        it.opcode      = op;
        it.class_index = 2'(cls);
        it.pixel_index = 16'(pix);
        it.pixel_value = 16'(val);
        send_item(it);
    endtask

    // drain all reads, let a trailing accumulate settle, then write the threshold
    task automatic write_threshold(logic signed [15:0] thr);
        t_cfg_item c;
        pix_ch.valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (250) @(posedge i_clk);
        c.pixel_threshold = thr;
        thr_ch.valid <= 1'b1;
        thr_ch.data  <= c;
        do @(posedge i_clk); while (!thr_ch.ready);
        thr_ch.valid <= 1'b0;
        sb.set_threshold(thr);
    endtask

    function automatic int pick_value();
        case ($urandom_range(0, 3))
            0: return $urandom_range(0, 65535) - 32768;
            1: return $urandom_range(0, 200) - 50;
            2: return $urandom_range(0, 1) ? 32767 : -32768;
            default: return $urandom_range(0, 4000);
        endcase
    endfunction

    // mostly frames of accumulates on a few hot pixels, with reads; some noise
    task automatic random_items(int count);
        int done_n, cls, k;
        done_n = 0;
        while (done_n < count) begin
            if ($urandom_range(0, 6) == 0) begin
                send_op(2'($urandom_range(0, 3)), $urandom_range(0, 3),
                        $urandom_range(0, 65535), $urandom_range(0, 65535) - 32768);
                done_n++;
            end else begin
                cls = $urandom_range(0, 3);
                k = $urandom_range(1, 10);
                repeat (k) begin
                    send_op(OP_ACCUM, cls, hot_pix[$urandom_range(0, 7)], pick_value());
                    done_n++;
                end
                if ($urandom_range(0, 5) != 0) begin
                    send_op(OP_EOF, cls, $urandom_range(0, 65535), pick_value());
                    done_n++;
                end
                if ($urandom_range(0, 2) == 0) begin
                    send_op(OP_READ, $urandom_range(0, 3), hot_pix[$urandom_range(0, 7)],
                            pick_value());
                    done_n++;
                end
            end
        end
    endtask

    initial begin
        int thr;
        sb = new();
        burst_left = 0;
        sent_items = 0;
        accum_items = 0;
        hot_pix[0] = 0;
        hot_pix[1] = 65535;
        for (int i = 2; i < 8; i++) hot_pix[i] = $urandom_range(0, 65535);
        i_rst_n = 1'b0;
        pix_ch.valid = 1'b0;
        pix_ch.data  = '0;
        thr_ch.valid = 1'b0;
        thr_ch.data  = '0;
        stat_ch.ready = 1'b0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // threshold zero: basic extremes and the zero-frame read
        write_threshold(16'sd0);
        send_op(OP_READ, 0, 5, 0);           // no frames yet
        send_op(OP_ACCUM, 0, 5, 32767);
        send_op(OP_ACCUM, 0, 5, 1);
        send_op(OP_ACCUM, 0, 5, 0);          // equal to threshold, dropped
        send_op(OP_ACCUM, 0, 5, -32768);     // below threshold
        send_op(OP_EOF, 0, 0, 0);
        send_op(OP_READ, 0, 5, 0);
        send_op(OP_ACCUM, 1, 65535, 100);
        send_op(OP_EOF, 1, 65535, -1);
        send_op(OP_EOF, 1, 0, 0);
        send_op(OP_READ, 1, 65535, 0);
        send_op(2'd3, 3, 65535, -1);         // unused opcode
        send_op(OP_ACCUM, 3, 0, 7);
        send_op(OP_EOF, 3, 0, 0);
        send_op(OP_READ, 3, 0, 0);           // single sample: zero variance
        send_op(OP_READ, 2, 1234, 0);        // class without frames

        // lowest threshold: negative sums
        write_threshold(-16'sd32768);
        send_op(OP_ACCUM, 2, 9, -32767);
        send_op(OP_ACCUM, 2, 9, -5);
        send_op(OP_ACCUM, 2, 9, -32768);     // equal to threshold, dropped
        send_op(OP_EOF, 2, 9, 0);
        send_op(OP_READ, 2, 9, 0);
        random_items(500);

        // highest threshold: nothing accumulates
        write_threshold(16'sd32767);
        random_items(250);

        repeat (3) begin
            thr = $urandom_range(0, 65535) - 32768;
            if ($urandom_range(0, 1)) thr = $urandom_range(0, 300) - 150;
            write_threshold(16'(thr));
            random_items(400);
        end

        pix_ch.valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (300) @(posedge i_clk);

        $display("sent %0d items (%0d accumulates), checked %0d statistics reads",
                 sent_items, accum_items, sb.reads_seen);
        $display("thresholds swept over both extremes and random values, %0d mismatches",
                 sb.mismatches);
        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end
endmodule
